[src/assert_macros.svh]
// assertion macros used by the decoder top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");
`define ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, cond)
`define ASSERT_IMPLY(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

[src/necir_pkg.sv]
// types, codes and reset constants of the nec ir frame decoder
package necir_pkg;

   localparam int TIME_W = 32;
   localparam int DUR_W = 16;
   localparam int DATA_W = 32;
   localparam int COUNT_W = 6;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [2:0] {
      PH_WAIT      = 3'd0,
      PH_HDR_BURST = 3'd1,
      PH_HDR_PAUSE = 3'd2,
      PH_BIT_BURST = 3'd3,
      PH_BIT_PAUSE = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      ST_IGNORED  = 2'd0,
      ST_ACCEPTED = 2'd1,
      ST_ERROR    = 2'd2,
      ST_FRAME    = 2'd3
   } status_type;

   localparam logic [CSR_IDX_W-1:0] REG_TOLERANCE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HEADER_BURST = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_HEADER_PAUSE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BIT_BURST    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ZERO_PAUSE   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ONE_PAUSE    = 3'd5;

   localparam logic [DUR_W-1:0] RST_TOLERANCE    = 16'd200;
   localparam logic [DUR_W-1:0] RST_HEADER_BURST = 16'd9000;
   localparam logic [DUR_W-1:0] RST_HEADER_PAUSE = 16'd4500;
   localparam logic [DUR_W-1:0] RST_BIT_BURST    = 16'd560;
   localparam logic [DUR_W-1:0] RST_ZERO_PAUSE   = 16'd560;
   localparam logic [DUR_W-1:0] RST_ONE_PAUSE    = 16'd1690;

   typedef struct packed {
      logic [DUR_W-1:0] tolerance_us;
      logic [DUR_W-1:0] header_burst_us;
      logic [DUR_W-1:0] header_pause_us;
      logic [DUR_W-1:0] bit_burst_us;
      logic [DUR_W-1:0] zero_pause_us;
      logic [DUR_W-1:0] one_pause_us;
   } cfg_type;

   typedef struct packed {
      phase_type         phase;
      logic              expect_rising;
      logic [TIME_W-1:0] last_edge_time;
      logic [DATA_W-1:0] shift_data;
   } state_type;

   typedef struct packed {
      status_type         status;
      logic [COUNT_W-1:0] bits_received;
      logic [DATA_W-1:0]  frame_data;
   } result_type;

   // strict fit on both sides, no wrap
   function automatic logic fits(input logic [TIME_W-1:0] dur,
                                 input logic [DUR_W-1:0] expected,
                                 input logic [DUR_W-1:0] tol);
      logic [TIME_W:0] lo_sum;
      logic [TIME_W:0] hi_sum;
      lo_sum = {1'b0, dur} + (TIME_W+1)'(tol);
      hi_sum = (TIME_W+1)'(expected) + (TIME_W+1)'(tol);
      return (lo_sum > (TIME_W+1)'(expected)) && ({1'b0, dur} < hi_sum);
   endfunction

endpackage

[src/necir_ifs.sv]
// handshake channels of the nec ir frame decoder
interface necir_req_if;
   import necir_pkg::*;
   logic              valid;
   logic              ready;
   logic              rising;
   logic [TIME_W-1:0] time_us;
   modport source (output valid, output rising, output time_us, input ready);
   modport sink (input valid, input rising, input time_us, output ready);
endinterface

interface necir_rsp_if;
   import necir_pkg::*;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic [COUNT_W-1:0] bits_received;
   logic [DATA_W-1:0]  frame_data;
   modport source (output valid, output status, output bits_received,
                   output frame_data, input ready);
   modport sink (input valid, input status, input bits_received,
                 input frame_data, output ready);
endinterface

interface necir_csr_if;
   import necir_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [DUR_W-1:0]     data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

[src/necir_csr.sv]
// timing configuration registers
module necir_csr import necir_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   necir_csr_if.sink   csr_bus,
   output cfg_type     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_bus.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            REG_TOLERANCE:    cfg_in.tolerance_us = csr_bus.data;
            REG_HEADER_BURST: cfg_in.header_burst_us = csr_bus.data;
            REG_HEADER_PAUSE: cfg_in.header_pause_us = csr_bus.data;
            REG_BIT_BURST:    cfg_in.bit_burst_us = csr_bus.data;
            REG_ZERO_PAUSE:   cfg_in.zero_pause_us = csr_bus.data;
            REG_ONE_PAUSE:    cfg_in.one_pause_us = csr_bus.data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tolerance_us <= RST_TOLERANCE;
         cfg_ff.header_burst_us <= RST_HEADER_BURST;
         cfg_ff.header_pause_us <= RST_HEADER_PAUSE;
         cfg_ff.bit_burst_us <= RST_BIT_BURST;
         cfg_ff.zero_pause_us <= RST_ZERO_PAUSE;
         cfg_ff.one_pause_us <= RST_ONE_PAUSE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[src/necir_step.sv]
// per-edge decode: next decoder state and the result of one edge
module necir_step import necir_pkg::*; #(
   parameter int FRAME_BITS = 32,
   parameter int CNT_W = 6
) (
   input  cfg_type            cfg,
   input  state_type          st,
   input  logic [CNT_W-1:0]   cnt,
   input  logic               rising,
   input  logic [TIME_W-1:0]  time_us,
   output state_type          st_nxt,
   output logic [CNT_W-1:0]   cnt_nxt,
   output result_type         res
);

   logic [TIME_W-1:0] dur;
   logic [CNT_W-1:0]  cnt_inc;
   logic [DATA_W-1:0] bit_mask;
   logic [DUR_W-1:0]  expected;
   logic              fit_zero;
   logic              fit_one;
   logic              fit_exp;

   assign dur = time_us - st.last_edge_time;
   assign cnt_inc = cnt + CNT_W'(1);
   assign bit_mask = DATA_W'(1) << cnt;
   assign fit_zero = fits(dur, cfg.zero_pause_us, cfg.tolerance_us);
   assign fit_one = fits(dur, cfg.one_pause_us, cfg.tolerance_us);
   assign fit_exp = fits(dur, expected, cfg.tolerance_us);

   always_comb begin
      case (st.phase)
         PH_HDR_BURST: expected = cfg.header_burst_us;
         PH_HDR_PAUSE: expected = cfg.header_pause_us;
         default:      expected = cfg.bit_burst_us;
      endcase
   end

   always_comb begin
      st_nxt = st;
      cnt_nxt = cnt;
      res.status = ST_ACCEPTED;
      res.bits_received = '0;
      res.frame_data = '0;
      if (rising != st.expect_rising) begin
         res.status = ST_IGNORED;
      end else begin
         case (st.phase)
            PH_BIT_PAUSE: begin
               if (fit_zero || fit_one) begin
                  if (!fit_zero) begin
                     st_nxt.shift_data = st.shift_data | bit_mask;
                  end
                  cnt_nxt = cnt_inc;
                  st_nxt.last_edge_time = time_us;
                  st_nxt.phase = PH_BIT_BURST;
                  st_nxt.expect_rising = 1'b0;
                  if (cnt_inc == CNT_W'(FRAME_BITS)) begin
                     res.status = ST_FRAME;
                  end
               end else begin
                  res.status = ST_ERROR;
               end
            end
            PH_HDR_BURST, PH_HDR_PAUSE, PH_BIT_BURST: begin
               if (fit_exp) begin
                  st_nxt.last_edge_time = time_us;
                  case (st.phase)
                     PH_HDR_BURST: begin
                        st_nxt.phase = PH_HDR_PAUSE;
                        st_nxt.expect_rising = 1'b1;
                     end
                     PH_HDR_PAUSE: begin
                        st_nxt.phase = PH_BIT_BURST;
                        st_nxt.expect_rising = 1'b0;
                     end
                     default: begin
                        st_nxt.phase = PH_BIT_PAUSE;
                        st_nxt.expect_rising = 1'b1;
                     end
                  endcase
               end else begin
                  res.status = ST_ERROR;
               end
            end
            default: begin
               st_nxt.last_edge_time = time_us;
               st_nxt.phase = PH_HDR_BURST;
               st_nxt.expect_rising = 1'b0;
            end
         endcase
      end

      res.bits_received = COUNT_W'(cnt_nxt);
      res.frame_data = st_nxt.shift_data;
      if (res.status == ST_FRAME) begin
         res.bits_received = COUNT_W'(FRAME_BITS);
      end
      // back to waiting after a frame or a timing error
      if (res.status == ST_FRAME || res.status == ST_ERROR) begin
         st_nxt.phase = PH_WAIT;
         st_nxt.expect_rising = 1'b1;
         st_nxt.shift_data = '0;
         cnt_nxt = '0;
      end
      if (res.status == ST_ERROR) begin
         res.bits_received = '0;
         res.frame_data = '0;
      end
   end

endmodule

[src/nec_ir_frame_decoder.sv]
// Decodes NEC infrared frames from timestamped receiver edges. Each req beat
// carries one edge (polarity and a 32-bit microsecond timestamp) and yields
// exactly one rsp beat with a status (ignored, accepted, timing error, frame
// complete), the bit count and the bits collected so far, LSB first. One
// edge is taken every clock cycle while rsp does not stall; each taken edge
// is held in the input register, and the combinational decode update then
// loads the result and decoder state registers. A stalled rsp channel holds
// one edge in the input register and then stalls req. Timing registers are
// written through the csr channel, which is always ready, and should be
// changed only while no edge is in flight.
`include "assert_macros.svh"

module nec_ir_frame_decoder import necir_pkg::*; #(
   parameter int FRAME_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   necir_req_if.sink   req_bus,
   necir_rsp_if.source rsp_bus,
   necir_csr_if.sink   csr_bus
);

   localparam int CNT_W = $clog2(FRAME_BITS + 1);

   cfg_type            cfg;
   logic               in_valid_ff;
   logic               in_rising_ff;
   logic [TIME_W-1:0]  in_time_ff;
   state_type          state_ff;
   state_type          state_in;
   logic [CNT_W-1:0]   cnt_ff;
   logic [CNT_W-1:0]   cnt_in;
   logic               rsp_valid_ff;
   result_type         rsp_ff;
   result_type         rsp_in;
   logic               advance;

   necir_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   necir_step #(
      .FRAME_BITS (FRAME_BITS),
      .CNT_W      (CNT_W)
   ) u_step (
      .cfg     (cfg),
      .st      (state_ff),
      .cnt     (cnt_ff),
      .rising  (in_rising_ff),
      .time_us (in_time_ff),
      .st_nxt  (state_in),
      .cnt_nxt (cnt_in),
      .res     (rsp_in)
   );

   assign advance = in_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.status = rsp_ff.status;
   assign rsp_bus.bits_received = rsp_ff.bits_received;
   assign rsp_bus.frame_data = rsp_ff.frame_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff.phase <= PH_WAIT;
         state_ff.expect_rising <= 1'b1;
         state_ff.last_edge_time <= '0;
         state_ff.shift_data <= '0;
         cnt_ff <= '0;
      end else begin
         if (req_bus.ready) begin
            in_valid_ff <= req_bus.valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            state_ff <= state_in;
            cnt_ff <= cnt_in;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_rising_ff <= req_bus.rising;
         in_time_ff <= req_bus.time_us;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   `ASSERT_NEXT(a_advance_loads_rsp, clock, reset, advance, rsp_valid_ff)
   `ASSERT_IMPLY(a_error_clears, clock, reset,
      rsp_valid_ff && rsp_ff.status == ST_ERROR,
      rsp_ff.bits_received == '0 && rsp_ff.frame_data == '0)
   `ASSERT_ALWAYS(a_count_in_frame, clock, reset, 32'(cnt_ff) < 32'(FRAME_BITS))
   `ASSERT_IMPLY(a_wait_is_clean, clock, reset, state_ff.phase == PH_WAIT,
      state_ff.expect_rising && cnt_ff == '0 && state_ff.shift_data == '0)

endmodule
